// ----- rtl/bbag_pkg.sv -----
// bbag_pkg: shared types and constants for the bounded bag.
// No dependencies; imported by bounded_bag_insert_query_remove.
`timescale 1ns / 1ps

package bbag_pkg;

	localparam int DATA_W        = 32;
	localparam int REQ_W         = 2;
	localparam int CAP_W         = 5;
	localparam int DEF_MAX_DEPTH = 16;

	localparam logic [CAP_W-1:0]         CAP_RESET = CAP_W'(16);
	localparam logic signed [DATA_W-1:0] MISS_MARK = 32'shFFFF7FF7;

	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT = 2'd0,
		REQ_QUERY  = 2'd1,
		REQ_REMOVE = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT
	} state_t;

endpackage

// ----- rtl/bounded_bag_insert_query_remove.sv -----
// Bounded bag: insert, query, remove-first-match over a packed entry memory; uses bbag_pkg.
// Insert or an unused code completes straight from idle; query and remove scan the entries in order,
// and a remove hit then shifts each later entry down one slot before done.
// One request at a time, the next accepted at the edge ending the done cycle.
// Reset clears the count and the state machine and sets the capacity register to 16.
// done pulses for one cycle with the result; the receiver cannot stall.
`timescale 1ns / 1ps

module bounded_bag_insert_query_remove
	import bbag_pkg::*;
#(
	parameter int MAX_DEPTH = DEF_MAX_DEPTH,
	localparam int CNT_W    = $clog2(MAX_DEPTH + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [REQ_W-1:0]         req_type,
	input  logic signed [DATA_W-1:0] item_value,
	output logic                     done,
	output logic                     success,
	output logic signed [DATA_W-1:0] result_value,
	output logic [CNT_W-1:0]         entry_count,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CAP_W-1:0]         cfg_data
);

	localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	logic signed [DATA_W-1:0] mem [MAX_DEPTH];

	state_t                   state_q, state_d;
	logic [CNT_W-1:0]         cnt_q, cnt_d;
	logic [CNT_W-1:0]         idx_q, idx_d;
	logic [CAP_W-1:0]         cap_q;
	logic signed [DATA_W-1:0] key_q;
	logic [REQ_W-1:0]         op_q;
	logic                     done_q, done_d;
	logic                     success_q, success_d;
	logic signed [DATA_W-1:0] result_value_q, result_value_d;

	logic                     cmp_vld_s1;
	logic [CNT_W-1:0]         cmp_idx_s1;
	logic signed [DATA_W-1:0] rd_data_s1;

	logic                     rd_en;
	logic                     we;
	logic [IDX_W-1:0]         wa;
	logic signed [DATA_W-1:0] wd;
	logic [CNT_W-1:0]         dst_idx;
	logic [CMP_W-1:0]         eff_cap;
	logic                     accept;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign dst_idx   = cmp_idx_s1 - CNT_W'(1);
	assign eff_cap   = (CMP_W'(cap_q) > CMP_W'(MAX_DEPTH)) ? CMP_W'(MAX_DEPTH) : CMP_W'(cap_q);

	assign done         = done_q;
	assign success      = success_q;
	assign result_value = result_value_q;
	assign entry_count  = cnt_q;

	always_comb begin
		state_d        = state_q;
		cnt_d          = cnt_q;
		idx_d          = idx_q;
		done_d         = 1'b0;
		success_d      = success_q;
		result_value_d = result_value_q;
		rd_en          = 1'b0;
		we             = 1'b0;
		wa             = cnt_q[IDX_W-1:0];
		wd             = item_value;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (req_t'(req_type))
						REQ_INSERT: begin
							done_d         = 1'b1;
							result_value_d = item_value;
							if (CMP_W'(cnt_q) < eff_cap) begin
								we        = 1'b1;
								cnt_d     = cnt_q + CNT_W'(1);
								success_d = 1'b1;
							end else begin
								success_d = 1'b0;
							end
						end
						REQ_QUERY, REQ_REMOVE: begin
							state_d = ST_SCAN;
							idx_d   = '0;
						end
						default: begin
							done_d         = 1'b1;
							success_d      = 1'b0;
							result_value_d = item_value;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (cmp_vld_s1 && (rd_data_s1 == key_q)) begin
					if (op_q == REQ_REMOVE) begin
						state_d = ST_SHIFT;
						idx_d   = cmp_idx_s1 + CNT_W'(1);
					end else begin
						state_d        = ST_IDLE;
						done_d         = 1'b1;
						success_d      = 1'b1;
						result_value_d = key_q;
					end
				end else if (idx_q < cnt_q) begin
					rd_en = 1'b1;
					idx_d = idx_q + CNT_W'(1);
				end else if (!cmp_vld_s1) begin
					state_d        = ST_IDLE;
					done_d         = 1'b1;
					success_d      = 1'b0;
					result_value_d = (op_q == REQ_REMOVE) ? MISS_MARK : key_q;
				end
			end
			ST_SHIFT: begin
				// move entry i to i-1, one read and one write per cycle
				if (cmp_vld_s1) begin
					we = 1'b1;
					wa = dst_idx[IDX_W-1:0];
					wd = rd_data_s1;
				end
				if (idx_q < cnt_q) begin
					rd_en = 1'b1;
					idx_d = idx_q + CNT_W'(1);
				end else if (!cmp_vld_s1) begin
					state_d        = ST_IDLE;
					cnt_d          = cnt_q - CNT_W'(1);
					done_d         = 1'b1;
					success_d      = 1'b1;
					result_value_d = key_q;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			idx_q      <= '0;
			cap_q      <= CAP_RESET;
			done_q     <= 1'b0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			cnt_q      <= cnt_d;
			idx_q      <= idx_d;
			done_q     <= done_d;
			cmp_vld_s1 <= rd_en;
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		success_q      <= success_d;
		result_value_q <= result_value_d;
		cmp_idx_s1     <= idx_q;
		if (accept) begin
			key_q <= item_value;
			op_q  <= req_type;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[idx_q[IDX_W-1:0]];
		end
	end

endmodule

// ----- test/bounded_bag_checker.sv -----
// bounded_bag_checker: watches the request, result and capacity channels of the bounded bag,
// predicts each result from its own copy of the bag and compares field by field.
// Depends on bbag_pkg.
`timescale 1ns / 1ps

module bounded_bag_checker
	import bbag_pkg::*;
#(
	parameter int DEPTH    = DEF_MAX_DEPTH,
	localparam int COUNT_W = $clog2(DEPTH + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic [REQ_W-1:0]         req_type,
	input  logic signed [DATA_W-1:0] item_value,
	input  logic                     done,
	input  logic                     success,
	input  logic signed [DATA_W-1:0] result_value,
	input  logic [COUNT_W-1:0]       entry_count,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [CAP_W-1:0]         cfg_data,
	output int                       outstanding,
	output int                       fail_count
);

	typedef struct packed {
		logic                     ok;
		logic signed [DATA_W-1:0] value;
		logic [COUNT_W-1:0]       count;
	} bag_reply_t;

	logic signed [DATA_W-1:0] bag_slots [DEPTH];
	int unsigned              bag_size;
	int unsigned              capacity;
	bag_reply_t               pending_replies [$];

	function automatic bag_reply_t apply_request(input logic [REQ_W-1:0] op,
			input logic signed [DATA_W-1:0] key);
		bag_reply_t  r;
		int unsigned hit;
		int unsigned room;
		r.ok    = 1'b0;
		r.value = key;
		room    = (capacity > DEPTH) ? DEPTH : capacity;
		hit     = bag_size;
		for (int i = 0; i < bag_size; i++)
			if (hit == bag_size && bag_slots[i] == key)
				hit = i;
		case (op)
			REQ_INSERT: begin
				if (bag_size < room) begin
					bag_slots[bag_size] = key;
					bag_size++;
					r.ok = 1'b1;
				end
			end
			REQ_QUERY: r.ok = (hit < bag_size);
			REQ_REMOVE: begin
				if (hit < bag_size) begin
					r.value = bag_slots[hit];
					for (int j = hit; j + 1 < bag_size; j++)
						bag_slots[j] = bag_slots[j + 1];
					bag_size--;
					r.ok = 1'b1;
				end else begin
					r.value = MISS_MARK;
				end
			end
			default: ;
		endcase
		r.count = COUNT_W'(bag_size);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bag_size    = 0;
			capacity    = 32'(CAP_RESET);
			pending_replies.delete();
			outstanding = 0;
			fail_count  = 0;
		end else begin
			bag_reply_t want;
			if (done) begin
				if (pending_replies.size() == 0) begin
					$display("%t: unexpected result: success %0d value %0d count %0d",
						$time, success, result_value, entry_count);
					fail_count++;
				end else begin
					want = pending_replies.pop_front();
					if (success !== want.ok) begin
						$display("%t: success expected %0d actual %0d",
							$time, want.ok, success);
						fail_count++;
					end
					if (result_value !== want.value) begin
						$display("%t: result_value expected %0d actual %0d",
							$time, want.value, result_value);
						fail_count++;
					end
					if (entry_count !== want.count) begin
						$display("%t: entry_count expected %0d actual %0d",
							$time, want.count, entry_count);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				pending_replies.push_back(apply_request(req_type, item_value));
			if (cfg_valid && cfg_ready)
				capacity = 32'(cfg_data);
			outstanding = pending_replies.size();
		end
	end

endmodule

// ----- test/bounded_bag_insert_query_remove_test.sv -----
// bounded_bag_insert_query_remove_test: drives directed and random insert/query/remove
// requests and capacity writes into the bounded bag; bounded_bag_checker does the checking.
// Depends on bbag_pkg, bounded_bag_insert_query_remove and bounded_bag_checker.
`timescale 1ns / 1ps

module bounded_bag_insert_query_remove_test;
	import bbag_pkg::*;

	localparam int DEPTH    = DEF_MAX_DEPTH;
	localparam int COUNT_W  = $clog2(DEPTH + 1);
	localparam int PHASES   = 10;
	localparam int PER_PHASE = 100;
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic [REQ_W-1:0]         req_type = REQ_INSERT;
	logic signed [DATA_W-1:0] item_value = '0;
	logic                     done;
	logic                     success;
	logic signed [DATA_W-1:0] result_value;
	logic [COUNT_W-1:0]       entry_count;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CAP_W-1:0]         cfg_data = '0;
	int                       outstanding;
	int                       fail_count;
	int                       idle_pct = 0;
	int                       insert_pct = 40;

	bounded_bag_insert_query_remove #(.MAX_DEPTH(DEPTH)) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .item_value(item_value),
		.done(done), .success(success), .result_value(result_value),
		.entry_count(entry_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	bounded_bag_checker #(.DEPTH(DEPTH)) bag_monitor (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .item_value(item_value),
		.done(done), .success(success), .result_value(result_value),
		.entry_count(entry_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.outstanding(outstanding), .fail_count(fail_count)
	);

	always #10 clk = ~clk;

	task automatic issue(input logic [REQ_W-1:0] op, input logic signed [DATA_W-1:0] key);
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		req_type   <= op;
		item_value <= key;
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_capacity(input int unsigned cap);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= CAP_W'(cap);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// mostly a small key pool so queries and removes hit, with extremes and the miss marker
	function automatic logic signed [DATA_W-1:0] pick_key();
		if ($urandom_range(99) < 15)
			return $urandom;
		case ($urandom_range(7))
			0: return 32'sd0;
			1: return 32'sd1;
			2: return -32'sd1;
			3: return MISS_MARK;
			4: return 32'sh80000000;
			5: return 32'sh7FFFFFFF;
			6: return 32'sd42;
			default: return -32'sd42;
		endcase
	endfunction

	function automatic logic [REQ_W-1:0] pick_op();
		int r;
		r = $urandom_range(99);
		if (r < 3)
			return REQ_UNUSED;
		if (r < 3 + insert_pct)
			return REQ_INSERT;
		if (r < 28 + insert_pct)
			return REQ_QUERY;
		return REQ_REMOVE;
	endfunction

	function automatic int unsigned phase_capacity(input int p);
		case (p)
			0: return 16;
			1: return 1;
			2: return 31;
			3: return 0;
			4: return 8;
			5: return 16;
			6: return 2;
			7: return 31;
			default: return $urandom_range(31);
		endcase
	endfunction

	initial begin
		#20_000_000;
		$display("bounded_bag_insert_query_remove_test: FAIL");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty bag, then fill a small bag past full
		write_capacity(3);
		issue(REQ_QUERY, 32'sd0);
		issue(REQ_REMOVE, 32'sd0);
		issue(REQ_INSERT, MISS_MARK);
		issue(REQ_INSERT, 32'sh7FFFFFFF);
		issue(REQ_INSERT, 32'sh80000000);
		issue(REQ_INSERT, 32'sd0);
		issue(REQ_QUERY, 32'sh80000000);
		issue(REQ_QUERY, 32'sd1);
		issue(REQ_REMOVE, MISS_MARK);
		issue(REQ_UNUSED, -32'sd1);
		issue(REQ_INSERT, -32'sd1);
		issue(REQ_INSERT, -32'sd1);
		// capacity zero, below the count
		write_capacity(0);
		issue(REQ_INSERT, 32'sd5);
		issue(REQ_REMOVE, -32'sd1);
		issue(REQ_INSERT, 32'sd5);
		// capacity above depth saturates; duplicates and shift-down
		write_capacity(31);
		issue(REQ_INSERT, 32'sd9);
		issue(REQ_INSERT, 32'sd9);
		issue(REQ_INSERT, MISS_MARK);
		issue(REQ_REMOVE, 32'sd9);
		issue(REQ_REMOVE, 32'sh7FFFFFFF);
		issue(REQ_QUERY, 32'sd9);
		issue(REQ_REMOVE, MISS_MARK);
		issue(REQ_REMOVE, MISS_MARK);

		for (int p = 0; p < PHASES; p++) begin
			write_capacity(phase_capacity(p));
			case (p % 4)
				1: idle_pct = 61;
				3: idle_pct = 7;
				default: idle_pct = 0;
			endcase
			insert_pct = (p % 2 == 0) ? 55 : 30;
			for (int n = 0; n < PER_PHASE; n++)
				issue(pick_op(), pick_key());
		end

		wait_idle();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("bounded_bag_insert_query_remove_test: PASS");
		else
			$display("bounded_bag_insert_query_remove_test: FAIL");
		$finish;
	end

endmodule
